[design/sha1h_pkg.sv]
// Shared types and constants for the SHA-1 message hasher.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package sha1h_pkg;

   // Payload of one request and of one digest word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_payload_type;

   // Where the datapath takes the next block byte from.
   typedef enum logic [1:0] {
      BYTE_INPUT,
      BYTE_PAD,
      BYTE_ZERO,
      BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         put;        // write one byte into the block
      byte_sel_type byte_sel;
      logic         count_len;  // add eight to the bit length
      logic         round;      // run one compression round
      logic         add;        // fold the round registers into the chain
      logic         clear;      // return to the initial hash state
      logic [2:0]   word_sel;   // chain word shown on the digest output
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] pos;
      logic       round_last;
   } dp_status_type;

   localparam logic [31:0] IV0 = 32'h67452301;
   localparam logic [31:0] IV1 = 32'hEFCDAB89;
   localparam logic [31:0] IV2 = 32'h98BADCFE;
   localparam logic [31:0] IV3 = 32'h10325476;
   localparam logic [31:0] IV4 = 32'hC3D2E1F0;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE        = 8'h80;
   localparam logic [5:0] LEN_POS         = 6'd56;
   localparam logic [5:0] PRE_LEN_POS     = 6'd55;
   localparam logic [5:0] BLOCK_LAST_POS  = 6'd63;
   localparam logic [6:0] ROUND_LAST      = 7'd79;
   localparam logic [2:0] LAST_WORD_INDEX = 3'd4;

endpackage

[design/sha1h_stream_if.sv]
// Valid/ready stream channel carrying one payload per request.
// The payload type is set where the channel is instantiated.
interface sha1h_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[design/sha1h_datapath.sv]
// Datapath of the SHA-1 hasher: byte packing, schedule shift line, round
// registers, chaining values and bit length. Depends on sha1h_pkg.
module sha1h_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  sha1h_pkg::dp_cmd_type    cmd,
   input  logic [7:0]              in_byte,
   output sha1h_pkg::dp_status_type status,
   output logic [31:0]             digest_word
);
   import sha1h_pkg::*;

   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] rr_ff [5];
   logic [31:0] rr_in [5];
   // sched_ff[0] holds the word used by the current round.
   logic [31:0] sched_ff [16];
   logic [31:0] sched_in [16];
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [6:0]  round_ff, round_in;

   logic [7:0]  byte_mux;
   logic [31:0] f_val, k_val, t_val, w_next, w_mix;

   always_comb begin
      case (cmd.byte_sel)
         BYTE_INPUT: byte_mux = in_byte;
         BYTE_PAD:   byte_mux = PAD_BYTE;
         BYTE_ZERO:  byte_mux = 8'h00;
         BYTE_LEN:   byte_mux = len_ff[63:56];
         default:    byte_mux = 8'h00;
      endcase
   end

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = (rr_ff[1] & rr_ff[2]) | (~rr_ff[1] & rr_ff[3]);
         k_val = K0;
      end else if (round_ff < 7'd40) begin
         f_val = rr_ff[1] ^ rr_ff[2] ^ rr_ff[3];
         k_val = K1;
      end else if (round_ff < 7'd60) begin
         f_val = (rr_ff[1] & rr_ff[2]) | (rr_ff[1] & rr_ff[3]) | (rr_ff[2] & rr_ff[3]);
         k_val = K2;
      end else begin
         f_val = rr_ff[1] ^ rr_ff[2] ^ rr_ff[3];
         k_val = K3;
      end
      t_val  = {rr_ff[0][26:0], rr_ff[0][31:27]} + f_val + rr_ff[4] + k_val + sched_ff[0];
      w_mix  = sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0];
      w_next = {w_mix[30:0], w_mix[31]};
   end

   always_comb begin
      chain_in = chain_ff;
      rr_in    = rr_ff;
      sched_in = sched_ff;
      acc_in   = acc_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      round_in = round_ff;

      if (cmd.put) begin
         acc_in = {acc_ff[15:0], byte_mux};
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'b11) begin
            for (int i = 0; i < 15; i++) sched_in[i] = sched_ff[i + 1];
            sched_in[15] = {acc_ff, byte_mux};
         end
         // The last byte of a block primes the compression.
         if (pos_ff == BLOCK_LAST_POS) begin
            rr_in    = chain_ff;
            round_in = 7'd0;
         end
         if (cmd.byte_sel == BYTE_LEN) len_in = {len_ff[55:0], 8'h00};
      end
      if (cmd.count_len) len_in = len_ff + 64'd8;

      if (cmd.round) begin
         rr_in[0] = t_val;
         rr_in[1] = rr_ff[0];
         rr_in[2] = {rr_ff[1][1:0], rr_ff[1][31:2]};
         rr_in[3] = rr_ff[2];
         rr_in[4] = rr_ff[3];
         for (int i = 0; i < 15; i++) sched_in[i] = sched_ff[i + 1];
         sched_in[15] = w_next;
         round_in = round_ff + 7'd1;
      end

      if (cmd.add) begin
         for (int i = 0; i < 5; i++) chain_in[i] = chain_ff[i] + rr_ff[i];
      end

      if (cmd.clear) begin
         chain_in[0] = IV0;
         chain_in[1] = IV1;
         chain_in[2] = IV2;
         chain_in[3] = IV3;
         chain_in[4] = IV4;
         len_in = 64'd0;
         pos_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff[0] <= IV0;
         chain_ff[1] <= IV1;
         chain_ff[2] <= IV2;
         chain_ff[3] <= IV3;
         chain_ff[4] <= IV4;
         len_ff      <= 64'd0;
         pos_ff      <= 6'd0;
         round_ff    <= 7'd0;
      end else begin
         chain_ff <= chain_in;
         len_ff   <= len_in;
         pos_ff   <= pos_in;
         round_ff <= round_in;
      end
   end

   always_ff @(posedge clock) begin
      rr_ff    <= rr_in;
      sched_ff <= sched_in;
      acc_ff   <= acc_in;
   end

   assign status.pos        = pos_ff;
   assign status.round_last = (round_ff == ROUND_LAST);
   assign digest_word       = chain_ff[cmd.word_sel];

endmodule

[design/sha1h_controller.sv]
// Controller of the SHA-1 hasher: sequences byte intake, padding, the
// 80 compression rounds and the digest output. Depends on sha1h_pkg.
module sha1h_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_byte_valid,
   input  logic                    req_end,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              word_index,
   output logic                    last_word,
   output sha1h_pkg::dp_cmd_type    cmd,
   input  sha1h_pkg::dp_status_type status
);
   import sha1h_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD80,
      ST_PADZ,
      ST_PADLEN,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   state_type  state_ff, state_in;
   state_type  resume_ff, resume_in;
   logic [2:0] out_idx_ff, out_idx_in;
   logic       ready_ff, valid_ff;

   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      out_idx_in   = out_idx_ff;
      cmd          = '0;
      cmd.byte_sel = BYTE_INPUT;
      cmd.word_sel = out_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               if (req_byte_valid) begin
                  cmd.put       = 1'b1;
                  cmd.count_len = 1'b1;
               end
               if (req_byte_valid && status.pos == BLOCK_LAST_POS) begin
                  state_in  = ST_ROUND;
                  resume_in = req_end ? ST_PAD80 : ST_IDLE;
               end else if (req_end) begin
                  state_in = ST_PAD80;
               end
            end
         end
         ST_PAD80: begin
            cmd.put      = 1'b1;
            cmd.byte_sel = BYTE_PAD;
            if (status.pos == BLOCK_LAST_POS) begin
               state_in  = ST_ROUND;
               resume_in = ST_PADZ;
            end else if (status.pos == PRE_LEN_POS) begin
               state_in = ST_PADLEN;
            end else begin
               state_in = ST_PADZ;
            end
         end
         ST_PADZ: begin
            cmd.byte_sel = BYTE_ZERO;
            if (status.pos == LEN_POS) begin
               state_in = ST_PADLEN;
            end else begin
               cmd.put = 1'b1;
               if (status.pos == BLOCK_LAST_POS) begin
                  state_in  = ST_ROUND;
                  resume_in = ST_PADZ;
               end
            end
         end
         ST_PADLEN: begin
            cmd.put      = 1'b1;
            cmd.byte_sel = BYTE_LEN;
            if (status.pos == BLOCK_LAST_POS) begin
               state_in  = ST_ROUND;
               resume_in = ST_OUT;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (status.round_last) state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add    = 1'b1;
            state_in   = resume_ff;
            out_idx_in = 3'd0;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (out_idx_ff == LAST_WORD_INDEX) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         resume_ff  <= ST_IDLE;
         out_idx_ff <= 3'd0;
         ready_ff   <= 1'b1;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         resume_ff  <= resume_in;
         out_idx_ff <= out_idx_in;
         ready_ff   <= (state_in == ST_IDLE);
         valid_ff   <= (state_in == ST_OUT);
      end
   end

   assign req_ready  = ready_ff;
   assign rsp_valid  = valid_ff;
   assign word_index = out_idx_ff;
   assign last_word  = (out_idx_ff == LAST_WORD_INDEX);

endmodule

[design/sha1_message_hasher_unit.sv]
// SHA-1 message hasher, top level. Joins the controller and the datapath.
// Depends on sha1h_pkg, sha1h_stream_if, sha1h_controller, sha1h_datapath.
//
// Usage: the message enters on req_chan, one byte per request, with
// byte_valid marking a real byte and end_of_message on the final request.
// An end request with byte_valid low closes the message without a byte, so
// the empty message is one such request. Requests without end_of_message
// produce nothing; an end request produces five digest words on rsp_chan,
// word_index 0 to 4, most significant first, last_word on the fifth.
// Timing: bytes that do not complete a block are taken one per cycle. The
// 64th byte of a block starts the compression, 80 rounds on a single round
// unit and then a fold into the chaining values; no request is taken during
// the rounds or the fold. After an end request the padding bytes go through
// the same byte path, followed by one or two compressions; they go at one
// per cycle but for a compression on the way and the step where the zero
// bytes give way to the length bytes. The words then come one per cycle
// while rsp_chan.ready is high; a stalled receiver holds the current word.
// No request is taken from the end request until the fifth word is
// accepted. Reset (synchronous) restores the initial chaining values and
// clears the length count; the block is ready the cycle after.
module sha1_message_hasher_unit (
   input logic            clock,
   input logic            reset,
   sha1h_stream_if.sink   req_chan,
   sha1h_stream_if.source rsp_chan
);
   import sha1h_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [31:0]   digest_word;
   logic [2:0]    word_index;
   logic          last_word;
   logic          req_ready;
   logic          rsp_valid;

   sha1h_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_byte_valid (req_chan.payload.byte_valid),
      .req_end        (req_chan.payload.end_of_message),
      .req_ready      (req_ready),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_chan.ready),
      .word_index     (word_index),
      .last_word      (last_word),
      .cmd            (cmd),
      .status         (status)
   );

   sha1h_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_chan.payload.data_byte),
      .status      (status),
      .digest_word (digest_word)
   );

   assign req_chan.ready               = req_ready;
   assign rsp_chan.valid               = rsp_valid;
   assign rsp_chan.payload.digest_word = digest_word;
   assign rsp_chan.payload.word_index  = word_index;
   assign rsp_chan.payload.last_word   = last_word;

endmodule

[design/sha1h_checker.sv]
// Port-level checker for the SHA-1 hasher, bound to the top level.
// Depends on sha1h_pkg and sha1_message_hasher_unit.
module sha1h_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_word,
   input logic [2:0]  rsp_index,
   input logic        rsp_last
);
   import sha1h_pkg::*;

   // Digest words of one message leave in order without gaps.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_valid && rsp_index == $past(rsp_index) + 3'd1)
      else $error("digest word index did not advance by one");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_index == LAST_WORD_INDEX))
      else $error("last_word does not match word_index");

   // No request is taken while a digest is being delivered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while digest pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_word) && $stable(rsp_index))
      else $error("stalled digest word changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("digest output valid after reset");

endmodule

bind sha1_message_hasher_unit sha1h_checker u_sha1h_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.payload.digest_word),
   .rsp_index (rsp_chan.payload.word_index),
   .rsp_last  (rsp_chan.payload.last_word)
);
